[hdl/smd_pkg.sv]
// Shared types and constants for the substring match detector.
`default_nettype none

package smd_pkg;

  // Queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Input command codes.
  localparam logic CMD_LOAD_PATTERN = 1'b0;
  localparam logic CMD_TEXT         = 1'b1;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEXT = 1'b1
  } op_t;

  // One classified beat on its way to the back.
  typedef struct packed {
    op_t        op;
    logic [7:0] byte_val;
    logic       restart;
    logic       emit;
  } item_t;

endpackage : smd_pkg

`default_nettype wire

[hdl/smd_front.sv]
// Front: classifies each input beat into an operation for the back.
`default_nettype none

module smd_front
  import smd_pkg::*;
(
  input  wire logic       in_command,
  input  wire logic [7:0] in_byte_value,
  input  wire logic       in_first_of_run,
  input  wire logic       in_last_of_run,
  output item_t           item
);

  always_comb begin
    item.byte_val = in_byte_value;
    item.restart  = in_first_of_run;
    case (in_command)
      CMD_LOAD_PATTERN: begin
        item.op   = OP_LOAD;
        // last mark on a pattern byte means nothing
        item.emit = 1'b0;
      end
      CMD_TEXT: begin
        item.op   = OP_TEXT;
        item.emit = in_last_of_run;
      end
      default: begin
        item.op   = OP_LOAD;
        item.emit = 1'b0;
      end
    endcase
  end

endmodule : smd_front

`default_nettype wire

[hdl/smd_queue.sv]
// Short queue of classified beats between the front and the back.
`default_nettype none

module smd_queue
  import smd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output logic       not_empty,
  output item_t      head
);

  item_t                  slots_r [QUEUE_DEPTH];
  logic [QUEUE_IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule : smd_queue

`default_nettype wire

[hdl/smd_back.sv]
// Back: shift-and cell row over the stored pattern, sticky match flag and result register.
`default_nettype none

module smd_back
  import smd_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 128
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  head_valid,
  input  wire item_t head,
  output logic       head_pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic       out_found
);

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);

  logic [7:0]             cell_byte_r [MAX_PATTERN];
  logic [LEN_W-1:0]       len_r, len_nxt;
  logic [MAX_PATTERN-1:0] last_mask_r, last_mask_nxt;  // one-hot at len-1
  logic [MAX_PATTERN-1:0] flags_r, flags_nxt;
  logic                   found_r, found_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_found_r, out_found_nxt;

  logic                   go;
  logic                   is_load, is_text;
  logic [LEN_W-1:0]       load_pos;
  logic                   load_room;
  logic [MAX_PATTERN-1:0] cell_eq;
  logic [MAX_PATTERN-1:0] flags_base, flags_shift;
  logic                   found_base, found_new, hit;

  assign is_load = (head.op == OP_LOAD);
  assign is_text = (head.op == OP_TEXT);

  // only a result-bearing beat has to wait on the output register
  assign head_pop = head_valid && (!(is_text && head.emit) || !out_valid_r || out_ready);
  assign go       = head_pop;

  assign load_pos  = head.restart ? '0 : len_r;
  assign load_room = (load_pos < LEN_W'(MAX_PATTERN));

  // per-cell compare against the broadcast text byte
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    assign cell_eq[k] = (cell_byte_r[k] == head.byte_val);
    if (k == 0) begin : g_head_cell
      assign flags_shift[k] = cell_eq[k];
    end else begin : g_tail_cell
      assign flags_shift[k] = flags_base[k-1] && cell_eq[k];
    end

    always_ff @(posedge clk) begin
      if (go && is_load && load_room && (load_pos == LEN_W'(k))) begin
        cell_byte_r[k] <= head.byte_val;
      end
    end
  end

  assign flags_base = head.restart ? '0 : flags_r;
  assign found_base = head.restart ? 1'b0 : found_r;
  assign hit        = |(flags_shift & last_mask_r);
  assign found_new  = (len_r != '0) ? (found_base || hit) : found_base;

  always_comb begin
    len_nxt       = len_r;
    last_mask_nxt = last_mask_r;
    flags_nxt     = flags_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_found_nxt = out_found_r;
    if (go) begin
      case (head.op)
        OP_LOAD: begin
          flags_nxt = '0;
          if (load_room) begin
            len_nxt       = load_pos + 1'b1;
            last_mask_nxt = MAX_PATTERN'(1) << load_pos;
          end else begin
            len_nxt = load_pos;
          end
        end
        OP_TEXT: begin
          if (head.emit) begin
            out_valid_nxt = 1'b1;
            out_found_nxt = found_new;
            flags_nxt     = '0;
            found_nxt     = 1'b0;
          end else begin
            flags_nxt = (len_r != '0) ? flags_shift : flags_base;
            found_nxt = found_new;
          end
        end
        default: begin
          flags_nxt = flags_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      last_mask_r <= '0;
      flags_r     <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      last_mask_r <= last_mask_nxt;
      flags_r     <= flags_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;

endmodule : smd_back

`default_nettype wire

[hdl/substring_match_detector.sv]
// Substring match detector top level: front classifier, beat queue and shift-and back end.
// Throughput: one beat per cycle while the result register does not stall; the shift-and cell row
// handles a whole text byte per cycle. A last text beat's result passes the queue, then the result reg.
// Input ready drops only when the 2-entry queue is full, i.e. after the result register stalls.
// Reset (rst_n, synchronous): pattern length, match flags, found flag, queue and result valid cleared;
// pattern bytes are left as they are and only read once rewritten.
`default_nettype none

module substring_match_detector
  import smd_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 128
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_command,
  input  wire logic [7:0] in_byte_value,
  input  wire logic       in_first_of_run,
  input  wire logic       in_last_of_run,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_found
);

  item_t front_item;
  item_t head_item;
  logic  q_full, q_not_empty, q_pop, q_push;

  smd_front u_front (
    .in_command      (in_command),
    .in_byte_value   (in_byte_value),
    .in_first_of_run (in_first_of_run),
    .in_last_of_run  (in_last_of_run),
    .item            (front_item)
  );

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  smd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_item)
  );

  smd_back #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_not_empty),
    .head       (head_item),
    .head_pop   (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_found  (out_found)
  );

endmodule : substring_match_detector

`default_nettype wire
